### rtl/csrs_pkg.sv
// Shared types and constants for the command sender retry session block.
// Holds command codes, session state codes and the channel payload structs.
// No dependencies.
`default_nettype none

package csrs_pkg;

	localparam int MAX_RESULT_BYTES = 64;
	localparam int LEN_W            = 7;
	localparam int SEQ_W            = 16;
	localparam int TIME_W           = 32;
	localparam int TMO_W            = 31;
	localparam int CNT_W            = 8;
	localparam int CODE_W           = 8;
	localparam int STATE_W          = 3;
	localparam int CMD_W            = 4;
	localparam int APB_AW           = 4;
	localparam int APB_DW           = 32;

	localparam logic [CMD_W-1:0] CMD_START      = 4'd0;
	localparam logic [CMD_W-1:0] CMD_TX_ACCEPT  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_TX_DONE    = 4'd2;
	localparam logic [CMD_W-1:0] CMD_TX_ERROR   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_POLL       = 4'd4;
	localparam logic [CMD_W-1:0] CMD_ACK        = 4'd5;
	localparam logic [CMD_W-1:0] CMD_IN_PROG    = 4'd6;
	localparam logic [CMD_W-1:0] CMD_RESULT     = 4'd7;
	localparam logic [CMD_W-1:0] CMD_RELEASE    = 4'd8;
	localparam logic [CMD_W-1:0] CMD_OUT_ORDER  = 4'd9;
	localparam logic [CMD_W-1:0] CMD_RESET      = 4'd10;

	localparam logic [STATE_W-1:0] ST_IDLE    = 3'd0;
	localparam logic [STATE_W-1:0] ST_READY   = 3'd1;
	localparam logic [STATE_W-1:0] ST_SENDING = 3'd2;
	localparam logic [STATE_W-1:0] ST_WAITING = 3'd3;
	localparam logic [STATE_W-1:0] ST_RESULT  = 3'd4;
	localparam logic [STATE_W-1:0] ST_FAILED  = 3'd5;
	localparam logic [STATE_W-1:0] ST_DESYNC  = 3'd6;

	localparam logic [1:0] REG_TIMEOUT   = 2'd0;
	localparam logic [1:0] REG_MAX_ATT   = 2'd1;
	localparam logic [1:0] REG_FIRST_SEQ = 2'd2;

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 31'd1000;
	localparam logic [CNT_W-1:0] MAX_ATT_RESET = 8'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [TIME_W-1:0] now_time;
		logic [SEQ_W-1:0]  sequence_req;
		logic [CODE_W-1:0] result_value;
		logic [7:0]        result_length;
		logic [SEQ_W-1:0]  rcv_expected_seq;
	} cmd_t;

	typedef struct packed {
		logic               ok;
		logic [STATE_W-1:0] session_state;
		logic               tx_active;
		logic [SEQ_W-1:0]   pending_seq;
		logic [SEQ_W-1:0]   next_seq;
		logic [CNT_W-1:0]   attempts;
		logic [CODE_W-1:0]  stored_result;
		logic [LEN_W-1:0]   stored_length;
		logic [SEQ_W-1:0]   receiver_expects;
	} rsp_t;

	typedef struct packed {
		logic [TMO_W-1:0] response_timeout;
		logic [CNT_W-1:0] max_attempt_limit;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/csrs_if.sv
// Valid/ready channel interfaces for the event input and the status output.
// Depends on csrs_pkg for the payload structs.
`default_nettype none

interface csrs_cmd_if;
	logic              valid;
	logic              ready;
	csrs_pkg::cmd_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface csrs_rsp_if;
	logic              valid;
	logic              ready;
	csrs_pkg::rsp_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/csrs_cfg_regs.sv
// APB configuration registers: response timeout, attempt limit, first sequence.
// Depends on csrs_pkg.
`default_nettype none

module csrs_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [csrs_pkg::APB_AW-1:0]   paddr,
	input  wire logic [csrs_pkg::APB_DW-1:0]   pwdata,
	output logic      [csrs_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output csrs_pkg::cfg_t                     cfg
);

	logic [csrs_pkg::TMO_W-1:0] timeout_q;
	logic [csrs_pkg::CNT_W-1:0] max_att_q;
	logic [csrs_pkg::SEQ_W-1:0] first_seq_q;
	logic                       wr_en;
	logic [1:0]                 reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= csrs_pkg::TIMEOUT_RESET;
			max_att_q   <= csrs_pkg::MAX_ATT_RESET;
			first_seq_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				csrs_pkg::REG_TIMEOUT:   timeout_q   <= pwdata[csrs_pkg::TMO_W-1:0];
				csrs_pkg::REG_MAX_ATT:   max_att_q   <= pwdata[csrs_pkg::CNT_W-1:0];
				csrs_pkg::REG_FIRST_SEQ: first_seq_q <= pwdata[csrs_pkg::SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			csrs_pkg::REG_TIMEOUT:   prdata = {1'b0, timeout_q};
			csrs_pkg::REG_MAX_ATT:   prdata = {24'd0, max_att_q};
			csrs_pkg::REG_FIRST_SEQ: prdata = {16'd0, first_seq_q};
			default:                 prdata = '0;
		endcase
	end

	assign cfg.response_timeout  = timeout_q;
	assign cfg.max_attempt_limit = max_att_q;

endmodule

`default_nettype wire

### rtl/csrs_session.sv
// Session state registers and the next-state logic for one event.
// Produces the acceptance flag and the post-event status snapshot.
// Depends on csrs_pkg.
`default_nettype none

module csrs_session (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire csrs_pkg::cfg_t   cfg,
	input  wire csrs_pkg::cmd_t   item,
	output csrs_pkg::rsp_t        rsp
);

	logic [csrs_pkg::STATE_W-1:0] mode_q, mode_d;
	logic                         active_q, active_d;
	logic [csrs_pkg::SEQ_W-1:0]   next_q, next_d;
	logic [csrs_pkg::SEQ_W-1:0]   pend_q, pend_d;
	logic [csrs_pkg::TIME_W-1:0]  last_q, last_d;
	logic [csrs_pkg::CNT_W-1:0]   att_q, att_d;
	logic [csrs_pkg::CODE_W-1:0]  code_q, code_d;
	logic [csrs_pkg::LEN_W-1:0]   len_q, len_d;
	logic [csrs_pkg::SEQ_W-1:0]   recv_q, recv_d;
	logic                         ok;
	logic                         fb_match, fb_state, fb_state_f, eot_ok, timed_out;
	logic [csrs_pkg::STATE_W-1:0] retry_mode;
	logic [csrs_pkg::TIME_W-1:0]  elapsed;

	assign fb_match   = (item.sequence_req == pend_q) && (att_q != '0);
	assign fb_state   = (mode_q == csrs_pkg::ST_WAITING) || (mode_q == csrs_pkg::ST_READY) ||
	                    ((mode_q == csrs_pkg::ST_SENDING) && (att_q > 8'd1));
	assign fb_state_f = fb_state || (mode_q == csrs_pkg::ST_FAILED);
	assign eot_ok     = active_q && ((mode_q == csrs_pkg::ST_SENDING) ||
	                    (mode_q == csrs_pkg::ST_RESULT) || (mode_q == csrs_pkg::ST_DESYNC));
	assign retry_mode = (att_q < cfg.max_attempt_limit) ? csrs_pkg::ST_READY
	                                                   : csrs_pkg::ST_FAILED;
	assign elapsed    = item.now_time - last_q;
	assign timed_out  = elapsed >= {1'b0, cfg.response_timeout};

	always_comb begin
		mode_d   = mode_q;
		active_d = active_q;
		next_d   = next_q;
		pend_d   = pend_q;
		last_d   = last_q;
		att_d    = att_q;
		code_d   = code_q;
		len_d    = len_q;
		recv_d   = recv_q;
		ok       = 1'b0;
		unique case (item.command)
			csrs_pkg::CMD_START: begin
				if (mode_q == csrs_pkg::ST_IDLE) begin
					pend_d = next_q;
					att_d  = '0;
					code_d = '0;
					mode_d = csrs_pkg::ST_READY;
					ok     = 1'b1;
				end
			end
			csrs_pkg::CMD_TX_ACCEPT: begin
				if ((mode_q == csrs_pkg::ST_READY) && (att_q < cfg.max_attempt_limit)) begin
					att_d    = att_q + 8'd1;
					active_d = 1'b1;
					mode_d   = csrs_pkg::ST_SENDING;
					ok       = 1'b1;
				end
			end
			csrs_pkg::CMD_TX_DONE: begin
				if (eot_ok) begin
					active_d = 1'b0;
					if (mode_q == csrs_pkg::ST_SENDING) begin
						last_d = item.now_time;
						mode_d = csrs_pkg::ST_WAITING;
					end
					ok = 1'b1;
				end
			end
			csrs_pkg::CMD_TX_ERROR: begin
				if (eot_ok) begin
					active_d = 1'b0;
					if (mode_q == csrs_pkg::ST_SENDING) begin
						mode_d = retry_mode;
					end
					ok = 1'b1;
				end
			end
			csrs_pkg::CMD_POLL: begin
				if ((mode_q == csrs_pkg::ST_WAITING) && timed_out) begin
					mode_d = retry_mode;
				end
				ok = 1'b1;
			end
			csrs_pkg::CMD_ACK, csrs_pkg::CMD_IN_PROG: begin
				if (fb_match && fb_state) begin
					if (mode_q == csrs_pkg::ST_READY) begin
						last_d = item.now_time;
						mode_d = csrs_pkg::ST_WAITING;
					end else if (mode_q == csrs_pkg::ST_WAITING) begin
						last_d = item.now_time;
					end
					ok = 1'b1;
				end
			end
			csrs_pkg::CMD_RESULT: begin
				if (fb_match && fb_state_f &&
				    (item.result_length <= 8'(csrs_pkg::MAX_RESULT_BYTES))) begin
					len_d  = item.result_length[csrs_pkg::LEN_W-1:0];
					code_d = item.result_value;
					next_d = pend_q + 16'd1;
					mode_d = csrs_pkg::ST_RESULT;
					ok     = 1'b1;
				end
			end
			csrs_pkg::CMD_RELEASE: begin
				if ((mode_q == csrs_pkg::ST_RESULT) && !active_q) begin
					mode_d   = csrs_pkg::ST_IDLE;
					active_d = 1'b0;
					pend_d   = '0;
					last_d   = '0;
					att_d    = '0;
					code_d   = '0;
					len_d    = '0;
					recv_d   = '0;
					ok       = 1'b1;
				end
			end
			csrs_pkg::CMD_OUT_ORDER: begin
				if (fb_match && fb_state_f) begin
					recv_d = item.rcv_expected_seq;
					mode_d = csrs_pkg::ST_DESYNC;
					ok     = 1'b1;
				end
			end
			csrs_pkg::CMD_RESET: begin
				if (!active_q) begin
					mode_d   = csrs_pkg::ST_IDLE;
					active_d = 1'b0;
					next_d   = item.sequence_req;
					pend_d   = '0;
					last_d   = '0;
					att_d    = '0;
					code_d   = '0;
					len_d    = '0;
					recv_d   = '0;
					ok       = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= csrs_pkg::ST_IDLE;
			active_q <= 1'b0;
			next_q   <= '0;
			pend_q   <= '0;
			last_q   <= '0;
			att_q    <= '0;
			code_q   <= '0;
			len_q    <= '0;
			recv_q   <= '0;
		end else if (en) begin
			mode_q   <= mode_d;
			active_q <= active_d;
			next_q   <= next_d;
			pend_q   <= pend_d;
			last_q   <= last_d;
			att_q    <= att_d;
			code_q   <= code_d;
			len_q    <= len_d;
			recv_q   <= recv_d;
		end
	end

	assign rsp.ok               = ok;
	assign rsp.session_state    = mode_d;
	assign rsp.tx_active        = active_d;
	assign rsp.pending_seq      = pend_d;
	assign rsp.next_seq         = next_d;
	assign rsp.attempts         = att_d;
	assign rsp.stored_result    = code_d;
	assign rsp.stored_length    = len_d;
	assign rsp.receiver_expects = recv_d;

	// A transmission is always in flight while the session is sending.
	a_sending_active: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == csrs_pkg::ST_SENDING) |-> active_q)
		else $error("sending state without an active transmission");

	// An idle session has nothing outstanding.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == csrs_pkg::ST_IDLE) |-> (!active_q && att_q == '0 && pend_q == '0))
		else $error("idle session holds stale state");

	// Session registers move only when an event is applied.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(en) |-> ($stable(mode_q) && $stable(att_q) && $stable(next_q)))
		else $error("session state changed without an event");

endmodule

`default_nettype wire

### rtl/command_sender_retry_session_unit.sv
// Sender side of a stop-and-wait command session: one event in, one status
// transaction out. Takes one event per clock cycle with no gaps while the output
// is not stalled; each accepted event waits in the input register while the
// session update, the only loop in the design, works out its status, and the
// status is then written to the output register. The input register and the
// output register keep the two channels apart, so a stalled output does not
// block acceptance until both registers are full. Configuration registers sit on
// an APB port with pready tied high. Depends on csrs_pkg, the channel interfaces,
// csrs_cfg_regs and csrs_session.
`default_nettype none

module command_sender_retry_session_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [csrs_pkg::APB_AW-1:0] paddr,
	input  wire logic [csrs_pkg::APB_DW-1:0] pwdata,
	output logic      [csrs_pkg::APB_DW-1:0] prdata,
	output logic                             pready,
	csrs_cmd_if.sink                         cmd_ch,
	csrs_rsp_if.source                       rsp_ch
);

	csrs_pkg::cfg_t cfg;
	csrs_pkg::cmd_t item_s1;
	csrs_pkg::rsp_t rsp_d;
	csrs_pkg::rsp_t rsp_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           advance;
	logic           take;

	csrs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	csrs_session u_session (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.rsp    (rsp_d)
	);

	assign advance      = valid_s1 && (!valid_s2 || rsp_ch.ready);
	assign cmd_ch.ready = !valid_s1 || advance;
	assign take         = cmd_ch.valid && cmd_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cmd_ch.payload;
		end
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp_ch.valid   = valid_s2;
	assign rsp_ch.payload = rsp_s2;

	// An empty input register always accepts.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> cmd_ch.ready)
		else $error("input register empty but not ready");

	// An applied event always lands in the output register.
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("event applied but no status transaction presented");

	// A full output register that is not taken holds off the session update.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp_ch.ready) |-> !advance)
		else $error("session advanced over a stalled status transaction");

endmodule

`default_nettype wire

### bench/command_sender_retry_session_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for command_sender_retry_session_unit: a directed walk through the session
// states, then random event sequences under several register settings and idling patterns.
// Depends on csrs_pkg, the channel interfaces and the RTL; every status transaction is checked.

module command_sender_retry_session_unit_tb;

	localparam int PERIOD = 8;
	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS = 10;
	localparam logic [csrs_pkg::CMD_W-1:0] CMD_UNKNOWN = 4'd15;

	typedef struct packed {
		csrs_pkg::cmd_t ev;
		logic fixed;
		csrs_pkg::rsp_t want;
	} drill_t;

	localparam csrs_pkg::rsp_t FREE = '0;
	localparam csrs_pkg::rsp_t IDLE_OK = {1'b1, csrs_pkg::ST_IDLE, 1'b0, 16'h0, 16'h0,
		8'h0, 8'h0, 7'h0, 16'h0};
	localparam csrs_pkg::rsp_t IDLE_REJ = {1'b0, csrs_pkg::ST_IDLE, 1'b0, 16'h0, 16'h0,
		8'h0, 8'h0, 7'h0, 16'h0};
	localparam csrs_pkg::rsp_t READY_OK = {1'b1, csrs_pkg::ST_READY, 1'b0, 16'h0, 16'h0,
		8'h0, 8'h0, 7'h0, 16'h0};
	localparam csrs_pkg::rsp_t WRAP_OK = {1'b1, csrs_pkg::ST_IDLE, 1'b0, 16'h0, 16'hFFFF,
		8'h0, 8'h0, 7'h0, 16'h0};

	localparam drill_t DRILL [27] = '{
		{csrs_pkg::CMD_POLL, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b1, IDLE_OK},
		{CMD_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, IDLE_REJ},
		{csrs_pkg::CMD_TX_ACCEPT, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b1, IDLE_REJ},
		{csrs_pkg::CMD_START, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b1, READY_OK},
		{csrs_pkg::CMD_TX_ACCEPT, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_RESET, 32'h0, 16'h5555, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_RELEASE, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_TX_ERROR, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_TX_ACCEPT, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_IN_PROG, 32'h10, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_TX_DONE, 32'hFFFF_FF00, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_POLL, 32'h0000_02E7, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_POLL, 32'h0000_02E8, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_TX_ACCEPT, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_TX_DONE, 32'd5, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_ACK, 32'd6, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_POLL, 32'd1006, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_RESULT, 32'd1007, 16'h0, 8'hAA, 8'd65, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_RESULT, 32'd1008, 16'h0, 8'hFF, 8'd64, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_RELEASE, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_RESET, 32'h0, 16'hFFFF, 8'h00, 8'h00, 16'h0, 1'b1, WRAP_OK},
		{csrs_pkg::CMD_START, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_TX_ACCEPT, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_TX_ERROR, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_TX_ACCEPT, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE},
		{csrs_pkg::CMD_OUT_ORDER, 32'h0, 16'hFFFF, 8'h00, 8'h00, 16'hFFFF, 1'b0, FREE},
		{csrs_pkg::CMD_TX_DONE, 32'h0, 16'h0, 8'h00, 8'h00, 16'h0, 1'b0, FREE}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [csrs_pkg::APB_AW-1:0] paddr;
	logic [csrs_pkg::APB_DW-1:0] pwdata;
	logic [csrs_pkg::APB_DW-1:0] prdata;
	logic pready;

	csrs_cmd_if cmd_ch ();
	csrs_rsp_if rsp_ch ();

	command_sender_retry_session_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_ch(cmd_ch),
		.rsp_ch(rsp_ch)
	);

	logic [csrs_pkg::STATE_W-1:0] st_mode;
	logic st_active;
	logic [csrs_pkg::SEQ_W-1:0] st_next;
	logic [csrs_pkg::SEQ_W-1:0] st_pending;
	logic [csrs_pkg::TIME_W-1:0] st_last;
	logic [csrs_pkg::CNT_W-1:0] st_attempts;
	logic [csrs_pkg::CODE_W-1:0] st_code;
	logic [csrs_pkg::LEN_W-1:0] st_len;
	logic [csrs_pkg::SEQ_W-1:0] st_rx;
	logic [csrs_pkg::TMO_W-1:0] cfg_timeout;
	logic [csrs_pkg::CNT_W-1:0] cfg_limit;

	csrs_pkg::rsp_t status_due [$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic void session_clear(input logic [csrs_pkg::SEQ_W-1:0] seq);
		st_mode = csrs_pkg::ST_IDLE;
		st_active = 1'b0;
		st_next = seq;
		st_pending = '0;
		st_last = '0;
		st_attempts = '0;
		st_code = '0;
		st_len = '0;
		st_rx = '0;
	endfunction

	function automatic csrs_pkg::rsp_t advance_session(input csrs_pkg::cmd_t ev);
		logic accepted;
		logic fb_match;
		logic fb_state;
		logic tx_end;
		logic [csrs_pkg::TIME_W-1:0] elapsed;
		csrs_pkg::rsp_t r;
		accepted = 1'b0;
		fb_match = (ev.sequence_req == st_pending) && (st_attempts != '0);
		fb_state = (st_mode == csrs_pkg::ST_WAITING) || (st_mode == csrs_pkg::ST_READY) ||
			((st_mode == csrs_pkg::ST_SENDING) && (st_attempts > 8'd1));
		tx_end = st_active && ((st_mode == csrs_pkg::ST_SENDING) ||
			(st_mode == csrs_pkg::ST_RESULT) || (st_mode == csrs_pkg::ST_DESYNC));
		elapsed = ev.now_time - st_last;
		case (ev.command)
			csrs_pkg::CMD_START: begin
				if (st_mode == csrs_pkg::ST_IDLE) begin
					st_pending = st_next;
					st_attempts = '0;
					st_code = '0;
					st_mode = csrs_pkg::ST_READY;
					accepted = 1'b1;
				end
			end
			csrs_pkg::CMD_TX_ACCEPT: begin
				if (st_mode == csrs_pkg::ST_READY && st_attempts < cfg_limit) begin
					st_attempts = st_attempts + 8'd1;
					st_active = 1'b1;
					st_mode = csrs_pkg::ST_SENDING;
					accepted = 1'b1;
				end
			end
			csrs_pkg::CMD_TX_DONE, csrs_pkg::CMD_TX_ERROR: begin
				if (tx_end) begin
					st_active = 1'b0;
					if (st_mode == csrs_pkg::ST_SENDING) begin
						if (ev.command == csrs_pkg::CMD_TX_DONE) begin
							st_last = ev.now_time;
							st_mode = csrs_pkg::ST_WAITING;
						end else begin
							st_mode = (st_attempts < cfg_limit) ? csrs_pkg::ST_READY :
								csrs_pkg::ST_FAILED;
						end
					end
					accepted = 1'b1;
				end
			end
			csrs_pkg::CMD_POLL: begin
				if (st_mode == csrs_pkg::ST_WAITING && elapsed >= {1'b0, cfg_timeout}) begin
					st_mode = (st_attempts < cfg_limit) ? csrs_pkg::ST_READY :
						csrs_pkg::ST_FAILED;
				end
				accepted = 1'b1;
			end
			csrs_pkg::CMD_ACK, csrs_pkg::CMD_IN_PROG: begin
				if (fb_match && fb_state) begin
					if (st_mode == csrs_pkg::ST_READY || st_mode == csrs_pkg::ST_WAITING) begin
						st_last = ev.now_time;
						st_mode = csrs_pkg::ST_WAITING;
					end
					accepted = 1'b1;
				end
			end
			csrs_pkg::CMD_RESULT: begin
				if (fb_match && ev.result_length <= 8'(csrs_pkg::MAX_RESULT_BYTES) &&
						(fb_state || st_mode == csrs_pkg::ST_FAILED)) begin
					st_len = ev.result_length[csrs_pkg::LEN_W-1:0];
					st_code = ev.result_value;
					st_next = st_pending + 16'd1;
					st_mode = csrs_pkg::ST_RESULT;
					accepted = 1'b1;
				end
			end
			csrs_pkg::CMD_RELEASE: begin
				if (st_mode == csrs_pkg::ST_RESULT && !st_active) begin
					session_clear(st_next);
					accepted = 1'b1;
				end
			end
			csrs_pkg::CMD_OUT_ORDER: begin
				if (fb_match && (fb_state || st_mode == csrs_pkg::ST_FAILED)) begin
					st_rx = ev.rcv_expected_seq;
					st_mode = csrs_pkg::ST_DESYNC;
					accepted = 1'b1;
				end
			end
			csrs_pkg::CMD_RESET: begin
				if (!st_active) begin
					session_clear(ev.sequence_req);
					accepted = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.ok = accepted;
		r.session_state = st_mode;
		r.tx_active = st_active;
		r.pending_seq = st_pending;
		r.next_seq = st_next;
		r.attempts = st_attempts;
		r.stored_result = st_code;
		r.stored_length = st_len;
		r.receiver_expects = st_rx;
		return r;
	endfunction

	function automatic logic [csrs_pkg::TIME_W-1:0] pick_time();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 40) return st_last + {1'b0, cfg_timeout} - 32'd1 + 32'($urandom_range(2));
		if (roll < 75) return st_last + 32'($urandom_range(2000));
		return $urandom;
	endfunction

	function automatic csrs_pkg::cmd_t pick_event();
		csrs_pkg::cmd_t ev;
		int unsigned roll;
		roll = $urandom_range(99);
		ev.command = csrs_pkg::CMD_POLL;
		ev.now_time = pick_time();
		ev.sequence_req = ($urandom_range(99) < 88) ? st_pending : 16'($urandom);
		ev.result_value = 8'($urandom);
		ev.result_length = ($urandom_range(99) < 90) ?
			8'($urandom_range(csrs_pkg::MAX_RESULT_BYTES)) :
			8'($urandom_range(255, csrs_pkg::MAX_RESULT_BYTES + 1));
		ev.rcv_expected_seq = 16'($urandom);
		if ($urandom_range(99) < 15) begin
			ev.command = 4'($urandom_range(15));
			ev.sequence_req = 16'($urandom);
			ev.now_time = $urandom;
			return ev;
		end
		case (st_mode)
			csrs_pkg::ST_IDLE: begin
				ev.command = (roll < 85) ? csrs_pkg::CMD_START : csrs_pkg::CMD_RESET;
			end
			csrs_pkg::ST_READY: begin
				ev.command = (roll < 70) ? csrs_pkg::CMD_TX_ACCEPT :
					(roll < 80) ? csrs_pkg::CMD_ACK :
					(roll < 88) ? csrs_pkg::CMD_IN_PROG :
					(roll < 95) ? csrs_pkg::CMD_RESULT : csrs_pkg::CMD_OUT_ORDER;
			end
			csrs_pkg::ST_SENDING: begin
				ev.command = (roll < 60) ? csrs_pkg::CMD_TX_DONE :
					(roll < 85) ? csrs_pkg::CMD_TX_ERROR :
					(roll < 90) ? csrs_pkg::CMD_ACK :
					(roll < 95) ? csrs_pkg::CMD_RESULT : csrs_pkg::CMD_OUT_ORDER;
			end
			csrs_pkg::ST_WAITING: begin
				ev.command = (roll < 40) ? csrs_pkg::CMD_POLL :
					(roll < 55) ? csrs_pkg::CMD_ACK :
					(roll < 62) ? csrs_pkg::CMD_IN_PROG :
					(roll < 90) ? csrs_pkg::CMD_RESULT : csrs_pkg::CMD_OUT_ORDER;
			end
			csrs_pkg::ST_RESULT: begin
				if (st_active && roll < 50) begin
					ev.command = (roll < 25) ? csrs_pkg::CMD_TX_DONE : csrs_pkg::CMD_TX_ERROR;
				end else begin
					ev.command = (roll < 85) ? csrs_pkg::CMD_RELEASE : csrs_pkg::CMD_RESET;
				end
			end
			csrs_pkg::ST_FAILED: begin
				ev.command = (roll < 50) ? csrs_pkg::CMD_RESET :
					(roll < 75) ? csrs_pkg::CMD_RESULT :
					(roll < 90) ? csrs_pkg::CMD_OUT_ORDER : csrs_pkg::CMD_POLL;
			end
			default: begin
				if (st_active && roll < 50) begin
					ev.command = (roll < 25) ? csrs_pkg::CMD_TX_DONE : csrs_pkg::CMD_TX_ERROR;
				end else begin
					ev.command = csrs_pkg::CMD_RESET;
				end
			end
		endcase
		if (ev.command == csrs_pkg::CMD_RESET) begin
			ev.sequence_req = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
		end
		return ev;
	endfunction

	function automatic string show(input csrs_pkg::rsp_t s);
		return $sformatf("ok=%0d state=%0d tx=%0d pend=%h next=%h att=%0d code=%h len=%0d rx=%h",
			s.ok, s.session_state, s.tx_active, s.pending_seq, s.next_seq, s.attempts,
			s.stored_result, s.stored_length, s.receiver_expects);
	endfunction

	task automatic check_status(input csrs_pkg::rsp_t want, input csrs_pkg::rsp_t got,
			input logic orphan);
		logic bad;
		bad = orphan || want.ok != got.ok || want.session_state != got.session_state ||
			want.tx_active != got.tx_active || want.pending_seq != got.pending_seq ||
			want.next_seq != got.next_seq || want.attempts != got.attempts ||
			want.stored_result != got.stored_result || want.stored_length != got.stored_length ||
			want.receiver_expects != got.receiver_expects;
		if (bad) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				if (orphan) begin
					$display("unexpected status transaction: %s", show(got));
				end else begin
					$display("status mismatch: expected %s", show(want));
					$display("                 actual   %s", show(got));
				end
			end
		end
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (rsp_ch.valid && rsp_ch.ready) begin
					if (status_due.size() == 0) begin
						check_status(FREE, rsp_ch.payload, 1'b1);
					end else begin
						check_status(status_due.pop_front(), rsp_ch.payload, 1'b0);
					end
				end
				rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic send_event(input csrs_pkg::cmd_t ev, input logic fixed,
			input csrs_pkg::rsp_t want);
		csrs_pkg::rsp_t snap;
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= ev;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		snap = advance_session(ev);
		status_due.push_back(fixed ? want : snap);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [csrs_pkg::APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			csrs_pkg::REG_TIMEOUT: cfg_timeout = value[csrs_pkg::TMO_W-1:0];
			csrs_pkg::REG_MAX_ATT: cfg_limit = value[csrs_pkg::CNT_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic run_random(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			send_event(pick_event(), 1'b0, FREE);
		end
	endtask

	initial begin
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.payload <= '0;
		cfg_timeout = csrs_pkg::TIMEOUT_RESET;
		cfg_limit = csrs_pkg::MAX_ATT_RESET;
		session_clear('0);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 35;
		sink_idle_pct = 49;
		foreach (DRILL[i]) send_event(DRILL[i].ev, DRILL[i].fixed, DRILL[i].want);

		drain();
		reg_write(csrs_pkg::REG_TIMEOUT, 32'd1);
		reg_write(csrs_pkg::REG_MAX_ATT, 32'd1);
		reg_write(csrs_pkg::REG_FIRST_SEQ, 32'h0000_FFFF);
		run_random(170);

		drain();
		reg_write(csrs_pkg::REG_TIMEOUT, 32'h7FFF_FFFF);
		reg_write(csrs_pkg::REG_MAX_ATT, 32'd255);
		reg_write(csrs_pkg::REG_FIRST_SEQ, 32'h0);
		src_idle_pct = 49;
		sink_idle_pct = 35;
		run_random(170);

		// A zero timeout makes every poll while waiting expire.
		drain();
		reg_write(csrs_pkg::REG_TIMEOUT, 32'h0);
		reg_write(csrs_pkg::REG_MAX_ATT, 32'd4);
		reg_write(csrs_pkg::REG_FIRST_SEQ, 32'($urandom_range(65535)));
		src_idle_pct = 0;
		sink_idle_pct = 0;
		run_random(150);

		// With an attempt limit of zero no transmission is ever accepted.
		drain();
		reg_write(csrs_pkg::REG_TIMEOUT, 32'($urandom_range(5000, 1)));
		reg_write(csrs_pkg::REG_MAX_ATT, 32'h0);
		run_random(30);

		drain();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### files.f
rtl/csrs_pkg.sv
rtl/csrs_if.sv
rtl/csrs_cfg_regs.sv
rtl/csrs_session.sv
rtl/command_sender_retry_session_unit.sv
bench/command_sender_retry_session_unit_tb.sv
